/* hdl/fir56_pkg.sv */
// Shared constants, types and the fixed coefficient table of the 56-tap FIR filter.
package fir56_pkg;

  localparam int TAPS           = 56;
  localparam int COEF_FRAC_BITS = 16;
  localparam int SAMPLE_W       = 32;
  localparam int OUT_W          = 41;
  localparam int TDATA_W        = ((OUT_W + 7) / 8) * 8;
  localparam int COEF_W         = COEF_FRAC_BITS + 8;
  localparam int PROD_W         = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W          = PROD_W + $clog2(TAPS);
  localparam int ADDR_W         = $clog2(TAPS);
  localparam int FILL_W         = $clog2(TAPS + 1);
  localparam int RND_W          = ACC_W + 1 - COEF_FRAC_BITS;
  localparam longint unsigned DEC_SCALE = 64'd10000000000;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t coef_arr_t [TAPS];

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic clear;
    logic en;
  } mac_ctrl_t;

  // Real coefficients in units of 1e-10, tap 0 (newest sample) first.
  localparam longint COEF_E10 [TAPS] = '{
    -64'sd355241819400, -64'sd293339896500, -64'sd184277449600, -64'sd53418475670,
    64'sd70231636950, 64'sd161762815600, 64'sd206566210400, 64'sd203266115800,
    64'sd162702390600, 64'sd103524012700, 64'sd45964239920, 64'sd5817527531,
    -64'sd9559211961, -64'sd2191111431, 64'sd18617342810, 64'sd40433304300,
    64'sd52342243280, 64'sd48510862920, 64'sd29604408870, 64'sd1815496232,
    -64'sd25919387010, -64'sd45358834460, -64'sd51808556950, -64'sd45422535300,
    -64'sd30671459820, -64'sd14310126580, -64'sd2740437883, 64'sd260722294,
    -64'sd5359717954, -64'sd16274916400, -64'sd27322958560, -64'sd33589596820,
    -64'sd32216514550, -64'sd23326257940, -64'sd9760510577, 64'sd4132650195,
    64'sd14202166770, 64'sd17969987350, 64'sd15412722800, 64'sd8771442423,
    64'sd1561848839, -64'sd2797065802, -64'sd2245901578, 64'sd3278853523,
    64'sd11887841480, 64'sd20577410750, 64'sd26270409820, 64'sd26973742340,
    64'sd22289941280, 64'sd13536792430, 64'sd3089253193, -64'sd6386689841,
    -64'sd12766707670, -64'sd15136918450, -64'sd13775160780, -64'sd16156173970
  };

  // Rounds each coefficient to COEF_FRAC_BITS fraction bits, ties away from zero.
  // Evaluated once at elaboration.
  function automatic coef_arr_t build_coef();
    coef_arr_t tbl;
    longint c;
    longint unsigned mag;
    longint unsigned q;
    for (int i = 0; i < TAPS; i++) begin
      c   = COEF_E10[i];
      mag = (c < 0) ? longint'(-c) : longint'(c);
      q   = ((mag << COEF_FRAC_BITS) + DEC_SCALE / 2) / DEC_SCALE;
      tbl[i] = (c < 0) ? -COEF_W'(q) : COEF_W'(q);
    end
    return tbl;
  endfunction

  localparam coef_arr_t COEF = build_coef();

endpackage

/* hdl/fir56_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fir56_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/fir56_mac.sv */
// Shared multiply-accumulate unit: one registered product and one accumulator.
module fir56_mac (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fir56_pkg::mac_ctrl_t                 ctrl,
  input  logic [fir56_pkg::SAMPLE_W-1:0]       sample,
  input  fir56_pkg::coef_t                     coef,
  output logic signed [fir56_pkg::ACC_W-1:0]   acc,
  output logic                                 busy
);

  logic signed [fir56_pkg::PROD_W-1:0] prod;
  logic                                prod_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctrl.en;
    end
    if (ctrl.en) begin
      prod <= $signed({1'b0, sample}) * coef;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + fir56_pkg::ACC_W'(prod);
    end
  end

  assign busy = prod_vld;

endmodule

/* hdl/fir56_round.sv */
// Negates the sum, rounds it half up to an integer by dropping the 16 fraction bits, and saturates to the output range.
module fir56_round (
  input  logic                                clk,
  input  logic                                start,
  input  logic signed [fir56_pkg::ACC_W-1:0]  acc,
  output logic signed [fir56_pkg::OUT_W-1:0]  result
);

  localparam logic signed [fir56_pkg::ACC_W:0] RND_HALF =
    (fir56_pkg::ACC_W + 1)'(1) << (fir56_pkg::COEF_FRAC_BITS - 1);

  logic signed [fir56_pkg::ACC_W:0]   neg_sum;
  logic signed [fir56_pkg::RND_W-1:0] r;
  logic [fir56_pkg::RND_W-fir56_pkg::OUT_W:0] upper;

  // Half minus the sum equals the negated sum plus half an output step.
  assign neg_sum = RND_HALF - {acc[fir56_pkg::ACC_W-1], acc};

  always_ff @(posedge clk) begin
    if (start) begin
      r <= neg_sum[fir56_pkg::ACC_W:fir56_pkg::COEF_FRAC_BITS];
    end
  end

  assign upper = r[fir56_pkg::RND_W-1:fir56_pkg::OUT_W-1];

  always_comb begin
    if (upper == '0 || upper == '1) begin
      result = r[fir56_pkg::OUT_W-1:0];
    end else if (r[fir56_pkg::RND_W-1]) begin
      result = {1'b1, {(fir56_pkg::OUT_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(fir56_pkg::OUT_W-1){1'b1}}};
    end
  end

endmodule

/* hdl/fir_56_tap_fixed_coeff.sv */
// Top level of the 56-tap fixed-coefficient FIR filter.
// Samples enter a 56-entry circular RAM. The first 55 transactions only fill it and are
// taken one per cycle with no result. From the 56th on, each sample starts a pass of one
// shared multiply-accumulate unit over all 56 taps, one tap per cycle, newest sample first,
// followed by pipeline drain and rounding: a producing sample occupies the input through
// the accept, the tap reads, the drain of the 2 pipeline stages, the round and the output
// load. The result sits in an output register, so a new sample is taken while it waits; a
// finished sum only stalls if the previous result has still not been taken.
module fir_56_tap_fixed_coeff (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [fir56_pkg::SAMPLE_W-1:0]  s_tdata,  // [31:0] sample
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [fir56_pkg::TDATA_W-1:0]   m_tdata   // [40:0] filtered, [47:41] zero
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_ROUND = 4'b1000
  } state_t;

  state_t                              state;
  logic [fir56_pkg::ADDR_W-1:0]        wptr;
  logic [fir56_pkg::ADDR_W-1:0]        rd_addr;
  logic [fir56_pkg::ADDR_W-1:0]        tap_cnt;
  logic [fir56_pkg::ADDR_W-1:0]        rd_tap;
  logic                                rd_vld;
  logic [fir56_pkg::FILL_W-1:0]        fill;
  logic signed [fir56_pkg::OUT_W-1:0]  out_data;

  logic                                s_fire;
  logic                                out_free;
  logic                                round_start;
  logic [fir56_pkg::SAMPLE_W-1:0]      ram_rdata;
  fir56_pkg::mac_ctrl_t                mac_ctrl;
  logic signed [fir56_pkg::ACC_W-1:0]  acc;
  logic                                mac_busy;
  logic signed [fir56_pkg::OUT_W-1:0]  rnd_result;

  assign s_tready    = (state == S_IDLE);
  assign s_fire      = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign round_start = (state == S_DRAIN) && !rd_vld && !mac_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      wptr    <= '0;
      rd_addr <= '0;
      tap_cnt <= '0;
      rd_vld  <= 1'b0;
      fill    <= '0;
    end else begin
      rd_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            wptr    <= (wptr == fir56_pkg::ADDR_W'(fir56_pkg::TAPS - 1)) ? '0 : wptr + 1'b1;
            rd_addr <= wptr;
            tap_cnt <= '0;
            if (fill != fir56_pkg::FILL_W'(fir56_pkg::TAPS)) begin
              fill <= fill + 1'b1;
            end
            if (fill >= fir56_pkg::FILL_W'(fir56_pkg::TAPS - 1)) begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          // Walk backward from the newest entry so the tap count is the coefficient index.
          rd_vld  <= 1'b1;
          rd_addr <= (rd_addr == '0) ? fir56_pkg::ADDR_W'(fir56_pkg::TAPS - 1)
                                     : rd_addr - 1'b1;
          tap_cnt <= tap_cnt + 1'b1;
          if (tap_cnt == fir56_pkg::ADDR_W'(fir56_pkg::TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (round_start) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_tap <= tap_cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_ROUND && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ROUND && out_free) begin
      out_data <= rnd_result;
    end
  end

  assign m_tdata = {{(fir56_pkg::TDATA_W - fir56_pkg::OUT_W){1'b0}}, out_data};

  assign mac_ctrl.clear = s_fire;
  assign mac_ctrl.en    = rd_vld;

  fir56_ram #(
    .WIDTH (fir56_pkg::SAMPLE_W),
    .DEPTH (fir56_pkg::TAPS)
  ) u_ram (
    .clk   (clk),
    .we    (s_fire),
    .waddr (wptr),
    .wdata (s_tdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  fir56_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .sample (ram_rdata),
    .coef   (fir56_pkg::COEF[rd_tap]),
    .acc    (acc),
    .busy   (mac_busy)
  );

  fir56_round u_round (
    .clk    (clk),
    .start  (round_start),
    .acc    (acc),
    .result (rnd_result)
  );

endmodule

/* hdl/fir56_checker.sv */
// Port-level checks of the 56-tap FIR filter, bound to its top level.
module fir56_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [fir56_pkg::SAMPLE_W-1:0]  s_tdata,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [fir56_pkg::TDATA_W-1:0]   m_tdata
);

  // A result waiting for the sink keeps its value.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output transaction changed while stalled");

  // The padding above the result is always zero.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[fir56_pkg::TDATA_W-1:fir56_pkg::OUT_W] == '0)
    else $error("output padding bits not zero");

  // A new result is loaded only while the input side is busy with the sum.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while the filter was idle");

  // A result never follows directly on an input transaction.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("result one cycle after an input transaction");

  // The input side is ready again when a new result appears, and no input transaction preceded it directly.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready && !$past(s_tvalid && s_tready))
    else $error("input state wrong around a result load");

endmodule

bind fir_56_tap_fixed_coeff fir56_checker u_checker (.*);
